// ----- design/mjesc_pkg.sv -----
package mjesc_pkg;

  // ASCII codes used by the literal
  localparam logic [6:0] CH_QUOTE  = 7'h22;
  localparam logic [6:0] CH_APOS   = 7'h27;
  localparam logic [6:0] CH_BSLASH = 7'h5C;
  localparam logic [6:0] CH_U      = 7'h75;
  localparam logic [6:0] CH_N      = 7'h6E;
  localparam logic [6:0] CH_R      = 7'h72;
  localparam logic [6:0] CH_T      = 7'h74;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned NPEND   = 3;
  localparam logic [3:0]  BYTE_ESC_LEN = 4'd6;  // \u00xx

  // one output unit: a single char, backslash + char, or \u escape
  typedef enum logic [1:0] {
    UK_NONE,
    UK_CHR,
    UK_ESC,
    UK_UESC
  } unit_kind_e;

  // everything one request emits, in order: open quote, escaped pending
  // bytes, main unit, close quote
  typedef struct packed {
    logic                  open;
    logic [1:0]            nflush;
    logic [NPEND-1:0][7:0] fbytes;
    unit_kind_e            main_kind;
    logic [6:0]            main_ch;
    logic [CP_W-1:0]       main_cp;
    logic [3:0]            main_len;
    logic                  close;
  } plan_t;

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [6:0] r;
    if (n < 4'd10) begin
      r = 7'h30 + {3'b000, n};
    end else begin
      r = 7'h57 + {3'b000, n};
    end
    return r;
  endfunction

endpackage

// ----- design/mjesc_front.sv -----
module mjesc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                last_byte_i,
  output mjesc_pkg::plan_t    plan_o,
  output logic                plan_nonempty_o
);

  logic                               at_start_q, at_start_d;
  logic [mjesc_pkg::NPEND-1:0][7:0]   pend_q;
  logic [1:0]                         pcnt_q, pcnt_d;
  logic [2:0]                         slen_q, slen_d;

  logic                        cont, has_p, do_dec, do_app;
  mjesc_pkg::unit_kind_e       f_kind;
  logic [6:0]                  f_ch;
  logic                        f_lead;
  logic [2:0]                  f_slen;
  logic [mjesc_pkg::CP_W-1:0]  dec_cp, b_cp;
  logic [3:0]                  dec_len;
  mjesc_pkg::plan_t            plan;

  assign cont  = (in_byte_i[7:6] == 2'b10);
  assign has_p = (pcnt_q != 2'd0);
  assign b_cp  = {{(mjesc_pkg::CP_W - 8){1'b0}}, in_byte_i};

  // complete sequence when this continuation fills it up
  assign do_dec = has_p && cont && (({1'b0, pcnt_q} + 3'd1) >= slen_q);
  assign do_app = has_p && cont && !do_dec && (pcnt_q != 2'd3);

  // classification of a byte seen with nothing pending
  always_comb begin
    f_kind = mjesc_pkg::UK_NONE;
    f_ch   = in_byte_i[6:0];
    f_lead = 1'b0;
    f_slen = 3'd0;
    unique case (in_byte_i)
      8'h5C: begin f_kind = mjesc_pkg::UK_ESC; f_ch = mjesc_pkg::CH_BSLASH; end
      8'h22: begin f_kind = mjesc_pkg::UK_ESC; f_ch = mjesc_pkg::CH_QUOTE; end
      8'h27: begin f_kind = mjesc_pkg::UK_ESC; f_ch = mjesc_pkg::CH_APOS; end
      8'h0A: begin f_kind = mjesc_pkg::UK_ESC; f_ch = mjesc_pkg::CH_N; end
      8'h0D: begin f_kind = mjesc_pkg::UK_ESC; f_ch = mjesc_pkg::CH_R; end
      8'h09: begin f_kind = mjesc_pkg::UK_ESC; f_ch = mjesc_pkg::CH_T; end
      default: begin
        if (in_byte_i < 8'h20) begin
          f_kind = mjesc_pkg::UK_UESC;
        end else if (!in_byte_i[7]) begin
          f_kind = mjesc_pkg::UK_CHR;
        end else if ((in_byte_i & 8'hE0) == 8'hC0) begin
          f_lead = 1'b1;
          f_slen = 3'd2;
        end else if ((in_byte_i & 8'hF0) == 8'hE0) begin
          f_lead = 1'b1;
          f_slen = 3'd3;
        end else if ((in_byte_i & 8'hF8) == 8'hF0) begin
          f_lead = 1'b1;
          f_slen = 3'd4;
        end else begin
          f_kind = mjesc_pkg::UK_UESC;
        end
      end
    endcase
  end

  // code point of a completed sequence
  always_comb begin
    case (slen_q)
      3'd2:    dec_cp = {10'd0, pend_q[0][4:0], in_byte_i[5:0]};
      3'd3:    dec_cp = {5'd0, pend_q[0][3:0], pend_q[1][5:0], in_byte_i[5:0]};
      default: dec_cp = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], in_byte_i[5:0]};
    endcase
    if (dec_cp[20]) begin
      dec_len = 4'd8;
    end else if (dec_cp[19:16] != 4'd0) begin
      dec_len = 4'd7;
    end else begin
      dec_len = 4'd6;
    end
  end

  always_comb begin
    plan           = '0;
    plan.open      = at_start_q;
    plan.close     = last_byte_i;
    plan.fbytes    = pend_q;
    plan.main_kind = mjesc_pkg::UK_NONE;
    plan.main_ch   = f_ch;
    plan.main_cp   = b_cp;
    plan.main_len  = mjesc_pkg::BYTE_ESC_LEN;
    plan.nflush    = 2'd0;
    pcnt_d         = pcnt_q;
    slen_d         = slen_q;

    if (do_dec) begin
      plan.main_kind = mjesc_pkg::UK_UESC;
      plan.main_cp   = dec_cp;
      plan.main_len  = dec_len;
      pcnt_d         = 2'd0;
      slen_d         = 3'd0;
    end else if (do_app) begin
      pcnt_d = pcnt_q + 2'd1;
      // cut off at the end: whole buffer escaped, this byte last
      if (last_byte_i) begin
        plan.nflush    = pcnt_q;
        plan.main_kind = mjesc_pkg::UK_UESC;
      end
    end else begin
      plan.nflush = pcnt_q;
      if (f_lead) begin
        pcnt_d = 2'd1;
        slen_d = f_slen;
        if (last_byte_i) begin
          plan.main_kind = mjesc_pkg::UK_UESC;
        end
      end else begin
        pcnt_d = 2'd0;
        slen_d = 3'd0;
        plan.main_kind = f_kind;
        if (f_kind == mjesc_pkg::UK_ESC) begin
          plan.main_len = 4'd2;
        end else if (f_kind == mjesc_pkg::UK_CHR) begin
          plan.main_len = 4'd1;
        end
      end
    end

    if (last_byte_i) begin
      pcnt_d = 2'd0;
      slen_d = 3'd0;
    end
  end

  assign at_start_d = last_byte_i;

  assign plan_o          = plan;
  assign plan_nonempty_o = plan.open || plan.close || (plan.nflush != 2'd0) ||
                           (plan.main_kind != mjesc_pkg::UK_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      pcnt_q     <= 2'd0;
      slen_q     <= 3'd0;
    end else if (accept_i) begin
      at_start_q <= at_start_d;
      pcnt_q     <= pcnt_d;
      slen_q     <= slen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (do_app) begin
        pend_q[pcnt_q] <= in_byte_i;
      end else if (!do_dec && f_lead) begin
        pend_q[0] <= in_byte_i;
      end
    end
  end

endmodule

// ----- design/mjesc_emit.sv -----
module mjesc_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mjesc_pkg::plan_t  plan_i,
  output logic              busy_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [6:0]        out_char_o,
  output logic              end_of_literal_o
);

  typedef enum logic [1:0] {
    SEG_OPEN,
    SEG_FLUSH,
    SEG_MAIN,
    SEG_CLOSE
  } seg_e;

  typedef struct packed {
    logic ok;
    seg_e seg;
  } seg_sel_t;

  function automatic seg_sel_t pick(input logic pf, input logic pm, input logic pc);
    seg_sel_t r;
    r.ok  = pf || pm || pc;
    r.seg = pf ? SEG_FLUSH : (pm ? SEG_MAIN : SEG_CLOSE);
    return r;
  endfunction

  mjesc_pkg::plan_t  plan_q;
  logic              plan_v_q;
  seg_e              seg_q;
  logic [1:0]        j_q;
  logic [2:0]        c_q;
  logic              out_v_q, out_end_q;
  logic [6:0]        out_char_q;

  logic                        step, unit_last, more_flush, item_done;
  logic                        pf, pm, pc;
  seg_sel_t                    nxt, first;
  mjesc_pkg::unit_kind_e       u_kind;
  logic [6:0]                  u_ch, ch;
  logic [mjesc_pkg::CP_W-1:0]  u_cp;
  logic [23:0]                 cpx;
  logic [3:0]                  u_len, nib_idx;
  logic [3:0]                  nib;

  assign pf = (plan_q.nflush != 2'd0);
  assign pm = (plan_q.main_kind != mjesc_pkg::UK_NONE);
  assign pc = plan_q.close;

  always_comb begin
    unique case (seg_q)
      SEG_OPEN:  nxt = pick(pf, pm, pc);
      SEG_FLUSH: nxt = pick(1'b0, pm, pc);
      SEG_MAIN:  nxt = pick(1'b0, 1'b0, pc);
      default:   nxt = pick(1'b0, 1'b0, 1'b0);
    endcase
  end

  always_comb begin
    if (plan_i.open) begin
      first.ok  = 1'b1;
      first.seg = SEG_OPEN;
    end else begin
      first = pick(plan_i.nflush != 2'd0, plan_i.main_kind != mjesc_pkg::UK_NONE,
                   plan_i.close);
    end
  end

  // current unit
  always_comb begin
    u_kind = mjesc_pkg::UK_CHR;
    u_ch   = mjesc_pkg::CH_QUOTE;
    u_cp   = '0;
    u_len  = 4'd1;
    unique case (seg_q)
      SEG_FLUSH: begin
        u_kind = mjesc_pkg::UK_UESC;
        u_cp   = {{(mjesc_pkg::CP_W - 8){1'b0}}, plan_q.fbytes[j_q]};
        u_len  = mjesc_pkg::BYTE_ESC_LEN;
      end
      SEG_MAIN: begin
        u_kind = plan_q.main_kind;
        u_ch   = plan_q.main_ch;
        u_cp   = plan_q.main_cp;
        u_len  = plan_q.main_len;
      end
      default: begin
      end
    endcase
  end

  assign cpx     = {{(24 - mjesc_pkg::CP_W){1'b0}}, u_cp};
  assign nib_idx = u_len - 4'd1 - {1'b0, c_q};

  always_comb begin
    case (nib_idx)
      4'd0:    nib = cpx[3:0];
      4'd1:    nib = cpx[7:4];
      4'd2:    nib = cpx[11:8];
      4'd3:    nib = cpx[15:12];
      4'd4:    nib = cpx[19:16];
      4'd5:    nib = cpx[23:20];
      default: nib = 4'd0;
    endcase
    if (c_q == 3'd0) begin
      ch = (u_kind == mjesc_pkg::UK_CHR) ? u_ch : mjesc_pkg::CH_BSLASH;
    end else if (c_q == 3'd1) begin
      ch = (u_kind == mjesc_pkg::UK_ESC) ? u_ch : mjesc_pkg::CH_U;
    end else begin
      ch = mjesc_pkg::hex_char(nib);
    end
  end

  assign step       = plan_v_q && (!out_v_q || !out_stall_i);
  assign unit_last  = ({1'b0, c_q} == (u_len - 4'd1));
  assign more_flush = (seg_q == SEG_FLUSH) &&
                      (({1'b0, j_q} + 3'd1) < {1'b0, plan_q.nflush});
  assign item_done  = step && unit_last && !more_flush && !nxt.ok;
  assign busy_o     = plan_v_q && !item_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_q     <= '0;
      plan_v_q   <= 1'b0;
      seg_q      <= SEG_OPEN;
      j_q        <= 2'd0;
      c_q        <= 3'd0;
      out_v_q    <= 1'b0;
      out_char_q <= 7'd0;
      out_end_q  <= 1'b0;
    end else begin
      if (load_i) begin
        plan_q   <= plan_i;
        plan_v_q <= 1'b1;
        seg_q    <= first.seg;
        j_q      <= 2'd0;
        c_q      <= 3'd0;
      end else if (step) begin
        if (!unit_last) begin
          c_q <= c_q + 3'd1;
        end else if (more_flush) begin
          j_q <= j_q + 2'd1;
          c_q <= 3'd0;
        end else if (nxt.ok) begin
          seg_q <= nxt.seg;
          c_q   <= 3'd0;
        end else begin
          plan_v_q <= 1'b0;
        end
      end
      if (step) begin
        out_v_q    <= 1'b1;
        out_char_q <= ch;
        out_end_q  <= (seg_q == SEG_CLOSE);
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_v_q;
  assign out_char_o       = out_char_q;
  assign end_of_literal_o = out_end_q;

endmodule

// ----- design/mutf8_to_java_escaped_literal_unit.sv -----
// Channel  Direction  Handshake              Payload
// in       request    in_valid_i/in_stall_o  in_byte_i, last_byte_i
// out      result     out_valid_o/out_stall_i out_char_o, end_of_literal_o
//
// Each request is decoded combinationally into an emit plan; the emitter then
// sends one character per cycle while out_stall_i allows, so a request yields
// as many characters as its plan holds (0 to 25), a plain printable byte one.
// A new request is taken in the cycle the previous plan sends its last char.
// Reset sets the string-start flag and clears the pending sequence count.
// out_stall_i holds the output register and, through it, the emitter.
module mutf8_to_java_escaped_literal_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  out_char_o,
  output logic        end_of_literal_o
);

  mjesc_pkg::plan_t plan;
  logic             plan_nonempty, accept, busy;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  mjesc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .last_byte_i     (last_byte_i),
    .plan_o          (plan),
    .plan_nonempty_o (plan_nonempty)
  );

  mjesc_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (accept && plan_nonempty),
    .plan_i           (plan),
    .busy_o           (busy),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .out_char_o       (out_char_o),
    .end_of_literal_o (end_of_literal_o)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int MAX_CHARS_PER_REQ = 25;
  localparam int PHASE_ITEMS       = 16;
  localparam int HOLD_CYCLES       = 300;
  localparam int TAIL_CYCLES       = 40;

  typedef enum int {
    PH_FREE,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH
  } idle_phase_e;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } str_byte_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       eol;
  } lit_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [6:0] out_char_o;
  logic       end_of_literal_o;

  mutf8_to_java_escaped_literal_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .end_of_literal_o (end_of_literal_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  str_byte_t   str_bytes_q[$];
  lit_char_t   lit_chars_q[$];
  idle_phase_e phase = PH_FREE;
  int          mismatch_cnt = 0;
  int          rand_items = 0;

  // escaper state
  logic       str_start = 1'b1;
  logic [7:0] seq_buf[3];
  int         seq_cnt = 0;
  int         seq_len = 0;
  int         req_chars;

  function automatic void emit(input logic [6:0] ch, input logic eol);
    lit_char_t c;
    if (req_chars < MAX_CHARS_PER_REQ) begin
      c.ch  = ch;
      c.eol = eol;
      lit_chars_q = {lit_chars_q, c};
      req_chars++;
    end
  endfunction

  function automatic logic [6:0] hex_lc(input logic [3:0] n);
    return (n < 4'd10) ? 7'h30 + 7'(n) : 7'h57 + 7'(n);
  endfunction

  function automatic void emit_uesc(input logic [20:0] cp);
    int digits;
    logic [23:0] cpx;
    cpx = {3'b000, cp};
    digits = (cp > 21'hFFFFF) ? 6 : (cp > 21'hFFFF) ? 5 : 4;
    emit(mjesc_pkg::CH_BSLASH, 1'b0);
    emit(mjesc_pkg::CH_U, 1'b0);
    for (int i = digits - 1; i >= 0; i--) emit(hex_lc(cpx[4*i +: 4]), 1'b0);
  endfunction

  function automatic void flush_seq();
    for (int i = 0; i < seq_cnt && i < 3; i++) emit_uesc(21'(seq_buf[i]));
    seq_cnt = 0;
    seq_len = 0;
  endfunction

  function automatic void escape_fresh(input logic [7:0] b);
    case (b)
      8'h5C: begin emit(mjesc_pkg::CH_BSLASH, 1'b0); emit(mjesc_pkg::CH_BSLASH, 1'b0); end
      8'h22: begin emit(mjesc_pkg::CH_BSLASH, 1'b0); emit(mjesc_pkg::CH_QUOTE, 1'b0); end
      8'h27: begin emit(mjesc_pkg::CH_BSLASH, 1'b0); emit(mjesc_pkg::CH_APOS, 1'b0); end
      8'h0A: begin emit(mjesc_pkg::CH_BSLASH, 1'b0); emit(mjesc_pkg::CH_N, 1'b0); end
      8'h0D: begin emit(mjesc_pkg::CH_BSLASH, 1'b0); emit(mjesc_pkg::CH_R, 1'b0); end
      8'h09: begin emit(mjesc_pkg::CH_BSLASH, 1'b0); emit(mjesc_pkg::CH_T, 1'b0); end
      default: begin
        if (b < 8'h20) begin
          emit_uesc(21'(b));
        end else if (b < 8'h80) begin
          emit(b[6:0], 1'b0);
        end else begin
          if ((b & 8'hE0) == 8'hC0) seq_len = 2;
          else if ((b & 8'hF0) == 8'hE0) seq_len = 3;
          else if ((b & 8'hF8) == 8'hF0) seq_len = 4;
          else seq_len = 0;
          if (seq_len == 0) begin
            emit_uesc(21'(b));
          end else begin
            seq_buf[0] = b;
            seq_cnt = 1;
          end
        end
      end
    endcase
  endfunction

  function automatic void decode_seq(input logic [7:0] last_cont);
    logic [20:0] cp;
    if (seq_len == 2) cp = 21'(seq_buf[0] & 8'h1F);
    else if (seq_len == 3) cp = 21'(seq_buf[0] & 8'h0F);
    else cp = 21'(seq_buf[0] & 8'h07);
    for (int i = 1; i < seq_cnt && i < 3; i++) cp = (cp << 6) | 21'(seq_buf[i] & 8'h3F);
    cp = (cp << 6) | 21'(last_cont & 8'h3F);
    emit_uesc(cp);
    seq_cnt = 0;
    seq_len = 0;
  endfunction

  function automatic void escape_request(input logic [7:0] b, input logic last);
    req_chars = 0;
    if (str_start) begin
      emit(mjesc_pkg::CH_QUOTE, 1'b0);
      str_start = 1'b0;
    end
    if (seq_cnt == 0) begin
      escape_fresh(b);
    end else if (b[7:6] == 2'b10) begin
      if (seq_cnt + 1 >= seq_len) begin
        decode_seq(b);
      end else if (seq_cnt < 3) begin
        seq_buf[seq_cnt] = b;
        seq_cnt++;
      end else begin
        flush_seq();
        escape_fresh(b);
      end
    end else begin
      // bad continuation: escape what is buffered, then take b afresh
      flush_seq();
      escape_fresh(b);
    end
    if (last) begin
      if (seq_cnt != 0) flush_seq();
      emit(mjesc_pkg::CH_QUOTE, 1'b1);
      str_start = 1'b1;
    end
  endfunction

  function automatic bit send_gap();
    case (phase)
      PH_SEND_GAPS: return $urandom_range(99, 0) < 46;
      PH_BOTH:      return $urandom_range(99, 0) < 13;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (phase)
      PH_RECV_STALLS: return $urandom_range(99, 0) < 46;
      PH_BOTH:        return $urandom_range(99, 0) < 13;
      default:        return 1'b0;
    endcase
  endfunction

  // request driver; the prediction is made as each request is taken
  always @(posedge clk_i or negedge rst_ni) begin
    str_byte_t nxt;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      in_byte_i   <= 8'h00;
      last_byte_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) escape_request(in_byte_i, last_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (str_bytes_q.size() != 0 && !send_gap()) begin
          nxt = str_bytes_q.pop_front();
          in_valid_i  <= 1'b1;
          in_byte_i   <= nxt.b;
          last_byte_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started by toggling hold_req
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= (hold_left > 1) || recv_stall();
    end
  end

  always @(posedge clk_i) begin
    lit_char_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lit_chars_q.size() == 0) begin
        $error("unexpected char: out_char %h end_of_literal %b", out_char_o, end_of_literal_o);
        mismatch_cnt++;
      end else begin
        e = lit_chars_q.pop_front();
        if (out_char_o !== e.ch) begin
          $error("out_char: expected %h, got %h", e.ch, out_char_o);
          mismatch_cnt++;
        end
        if (end_of_literal_o !== e.eol) begin
          $error("end_of_literal: expected %b, got %b", e.eol, end_of_literal_o);
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic last);
    str_byte_t s;
    s.b    = b;
    s.last = last;
    str_bytes_q = {str_bytes_q, s};
  endtask

  function automatic logic [7:0] lead_of(input int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      2:       r = {3'b110, r[4:0]};
      3:       r = {4'b1110, r[3:0]};
      default: r = {5'b11110, r[2:0]};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  // one string: mostly well-formed units, some noise and broken sequences
  task automatic add_random_string();
    logic [7:0] bytes_q[$];
    logic [7:0] r;
    int n_units;
    int kind;
    int len;
    int k;
    n_units = $urandom_range(6, 1);
    for (int u = 0; u < n_units; u++) begin
      kind = $urandom_range(9, 0);
      case (kind)
        0, 1, 2: bytes_q = {bytes_q, 8'($urandom_range(8'h7F, 8'h20))};
        3: begin
          k = $urandom_range(3, 0);
          if (k == 0) bytes_q = {bytes_q, 8'($urandom_range(8'h1F, 0))};
          else if (k == 1) bytes_q = {bytes_q, 8'h5C};
          else if (k == 2) bytes_q = {bytes_q, 8'h22};
          else bytes_q = {bytes_q, 8'h27};
        end
        4, 5, 6: begin
          len = kind - 2;
          bytes_q = {bytes_q, lead_of(len)};
          for (int i = 1; i < len; i++) bytes_q = {bytes_q, cont_byte()};
        end
        7: begin
          len = $urandom_range(4, 2);
          k = $urandom_range(len - 2, 0);
          bytes_q = {bytes_q, lead_of(len)};
          for (int i = 0; i < k; i++) bytes_q = {bytes_q, cont_byte()};
          r = 8'($urandom);
          if (r[7:6] == 2'b10) r[6] = 1'b1;
          bytes_q = {bytes_q, r};
        end
        8: bytes_q = {bytes_q, 8'($urandom)};
        default: begin
          // may end up cut off by the end of the string
          len = $urandom_range(4, 2);
          k = $urandom_range(len - 2, 0);
          bytes_q = {bytes_q, lead_of(len)};
          for (int i = 0; i < k; i++) bytes_q = {bytes_q, cont_byte()};
        end
      endcase
    end
    for (int i = 0; i < bytes_q.size(); i++) add_byte(bytes_q[i], i == bytes_q.size() - 1);
    rand_items += bytes_q.size();
  endtask

  task automatic run_phase(input idle_phase_e ph, input bit with_hold);
    int goal;
    phase = ph;
    if (with_hold) hold_req = ~hold_req;
    goal = rand_items + PHASE_ITEMS;
    while (rand_items < goal) add_random_string();
    while (str_bytes_q.size() != 0 || in_valid_i || lit_chars_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // escapes, control bytes, printable edges
    add_byte(8'h22, 1'b0);
    add_byte(8'h5C, 1'b0);
    add_byte(8'h27, 1'b0);
    add_byte(8'h0A, 1'b0);
    add_byte(8'h0D, 1'b0);
    add_byte(8'h09, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h1F, 1'b0);
    add_byte(8'h20, 1'b0);
    add_byte(8'h7F, 1'b1);
    // invalid leads, then two- and three-byte sequences
    add_byte(8'h80, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hF8, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'hAC, 1'b1);
    // six-digit code point, bad continuation after three buffered, cut-off end
    add_byte(8'hF7, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h90, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h22, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h90, 1'b1);
    // single-byte string
    add_byte(8'h41, 1'b1);
    while (str_bytes_q.size() != 0 || in_valid_i || lit_chars_q.size() != 0) @(negedge clk_i);

    run_phase(PH_FREE, 1'b0);
    run_phase(PH_SEND_GAPS, 1'b0);
    run_phase(PH_RECV_STALLS, 1'b0);
    run_phase(PH_BOTH, 1'b0);
    run_phase(PH_FREE, 1'b1);

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0 && lit_chars_q.size() == 0) begin
      $display("[mutf8_to_java_escaped_literal_unit] OK");
    end else begin
      $display("[mutf8_to_java_escaped_literal_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[mutf8_to_java_escaped_literal_unit] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mjesc_pkg.sv
design/mjesc_front.sv
design/mjesc_emit.sv
design/mutf8_to_java_escaped_literal_unit.sv
sim/tb.sv
